>>> rtl/cts_pkg.sv
// Shared types and constants for the CAN transmit scheduler.
package cts_pkg;

    typedef enum logic [1:0] {
        MODE_PUSH_PROC = 2'd0,
        MODE_PUSH_SERV = 2'd1,
        MODE_TICK      = 2'd2,
        MODE_RECV      = 2'd3
    } mode_t;

    localparam logic [1:0] REG_BUSY_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_RETRY_INTERVAL = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT    = 2'd2;

    localparam logic [15:0] BUSY_TIMEOUT_RESET   = 16'd20;
    localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd3;
    localparam logic [7:0]  RETRY_LIMIT_RESET    = 8'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [10:0] frame_id;
        logic        remote_request;
        logic        ack_request;
        logic [3:0]  length_code;
        logic [15:0] data_w0;
        logic [15:0] data_w1;
        logic [15:0] data_w2;
        logic [15:0] data_w3;
        logic [15:0] time_ms;
        logic        tx_done;
    } in_word_t;

    typedef struct packed {
        logic        send_valid;
        logic [10:0] send_id;
        logic        send_remote;
        logic [3:0]  send_length;
        logic [15:0] send_w0;
        logic [15:0] send_w1;
        logic [15:0] send_w2;
        logic [15:0] send_w3;
        logic        retry_fault;
        logic        push_dropped;
        logic        ack_matched;
        logic        busy_res;
    } out_word_t;

    typedef struct packed {
        logic [10:0] id;
        logic        remote;
        logic        ack;
        logic [3:0]  len;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
    } frame_t;

    // controller -> datapath
    typedef struct packed {
        logic step;
        logic push_proc;
        logic push_serv;
        logic pop_proc;
        logic drop_serv;
        logic pop_serv;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic proc_empty;
        logic proc_full;
        logic serv_empty;
        logic serv_full;
        logic serv_next_empty;
        frame_t proc_head;
        frame_t serv_head;
        frame_t serv_next;
    } dp_status_t;

endpackage

>>> rtl/can_tx_scheduler_with_ack_retry_core.sv
// Top level of the CAN transmit scheduler with acknowledgement retry.
// Input words (in_valid/in_ready) push a process or service frame, give a
// millisecond tick, or present a received frame for ack matching.
// Every accepted word yields exactly one result word on out_valid/out_ready.
// Each result is registered and leaves in the cycle after its word is
// taken; one word per cycle is sustained while the result register drains.
// The result register parts the two sides: a new word is taken while the
// previous result is taken in the same cycle; a stalled receiver holds it
// and stops input until it is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered.
// Reset empties both queues, clears timers and pending ack, and loads
// timeout 20 ms, retry interval 3 ms and retry limit 3.
// When a finished request is dropped on an idle tick, the next service
// frame goes out on that same tick.
module can_tx_scheduler_with_ack_retry_core #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  cts_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output cts_pkg::out_word_t out_word
);
    import cts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    frame_t     push_frame;

    cts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cmd(cmd), .push_frame(push_frame), .status(status)
    );

    cts_queues #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queues (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .push_frame(push_frame), .status(status)
    );

endmodule

>>> rtl/cts_queues.sv
// Datapath: process and service frame ring queues.
module cts_queues #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cts_pkg::dp_cmd_t    cmd,
    input  cts_pkg::frame_t     push_frame,
    output cts_pkg::dp_status_t status
);
    import cts_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

    frame_t proc_mem [QUEUE_DEPTH];
    frame_t serv_mem [QUEUE_DEPTH];
    logic [PW-1:0] ph_reg, pt_reg, sh_reg, st_reg;
    logic [PW-1:0] ph_next, pt_next, sh_next, st_next;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        ph_next = ph_reg;
        pt_next = pt_reg;
        sh_next = sh_reg;
        st_next = st_reg;
        if (cmd.step && cmd.push_proc) pt_next = inc(pt_reg);
        if (cmd.step && cmd.push_serv) st_next = inc(st_reg);
        if (cmd.step && cmd.pop_proc)  ph_next = inc(ph_reg);
        if (cmd.step && cmd.drop_serv && cmd.pop_serv) sh_next = inc(inc(sh_reg));
        else if (cmd.step && (cmd.drop_serv || cmd.pop_serv)) sh_next = inc(sh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= '0;
            pt_reg <= '0;
            sh_reg <= '0;
            st_reg <= '0;
        end
        else
        begin
            ph_reg <= ph_next;
            pt_reg <= pt_next;
            sh_reg <= sh_next;
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && cmd.push_proc) proc_mem[pt_reg] <= push_frame;
        if (cmd.step && cmd.push_serv) serv_mem[st_reg] <= push_frame;
    end

    assign status.proc_empty      = (ph_reg == pt_reg);
    assign status.proc_full       = (inc(pt_reg) == ph_reg);
    assign status.serv_empty      = (sh_reg == st_reg);
    assign status.serv_full       = (inc(st_reg) == sh_reg);
    assign status.serv_next_empty = (inc(sh_reg) == st_reg);
    assign status.proc_head       = proc_mem[ph_reg];
    assign status.serv_head       = serv_mem[sh_reg];
    assign status.serv_next       = serv_mem[inc(sh_reg)];

endmodule

>>> rtl/cts_ctrl.sv
// Controller: tick timers, busy state, ack retry and result register.
module cts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  cts_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output cts_pkg::out_word_t  out_word,
    output cts_pkg::dp_cmd_t    cmd,
    output cts_pkg::frame_t     push_frame,
    input  cts_pkg::dp_status_t status
);
    import cts_pkg::*;

    typedef enum logic {ST_EMPTY, ST_FULL} ost_t;

    ost_t state_reg, state_next;
    out_word_t res_reg, res_next;
    logic [15:0] bto_reg, rint_reg;
    logic [7:0]  rlim_reg;
    logic [15:0] last_reg, busy_ms_reg, retry_ms_reg;
    logic [15:0] last_next, busy_ms_next, retry_ms_next;
    logic tx_busy_reg, tx_busy_next, await_reg, await_next;
    logic [7:0] att_reg, att_next;
    logic [15:0] pidx_reg, pidx_next;
    logic [7:0]  psub_reg, psub_next;
    logic [6:0]  pnode_reg, pnode_next;
    logic step;
    frame_t f;
    logic s_empty;

    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = (state_reg == ST_FULL);
    assign out_word  = res_reg;

    always_comb
    begin
        push_frame        = '0;
        push_frame.id     = in_word.frame_id;
        push_frame.remote = in_word.remote_request;
        push_frame.ack    = (mode_t'(in_word.mode) == MODE_PUSH_SERV) && in_word.ack_request;
        push_frame.len    = in_word.length_code;
        push_frame.w0     = in_word.data_w0;
        push_frame.w1     = in_word.data_w1;
        push_frame.w2     = in_word.data_w2;
        push_frame.w3     = in_word.data_w3;
    end

    always_comb
    begin
        cmd           = '0;
        cmd.step      = step;
        res_next      = '0;
        last_next     = last_reg;
        busy_ms_next  = busy_ms_reg;
        retry_ms_next = retry_ms_reg;
        tx_busy_next  = tx_busy_reg;
        await_next    = await_reg;
        att_next      = att_reg;
        pidx_next     = pidx_reg;
        psub_next     = psub_reg;
        pnode_next    = pnode_reg;
        f             = status.serv_head;
        s_empty       = status.serv_empty;
        unique case (mode_t'(in_word.mode))
            MODE_PUSH_PROC:
            begin
                if (status.proc_full) res_next.push_dropped = 1'b1;
                else cmd.push_proc = 1'b1;
            end
            MODE_PUSH_SERV:
            begin
                if (status.serv_full) res_next.push_dropped = 1'b1;
                else cmd.push_serv = 1'b1;
            end
            MODE_TICK:
            begin
                if (in_word.time_ms != last_reg)
                begin
                    last_next = in_word.time_ms;
                    if (busy_ms_next != 16'hFFFF) busy_ms_next = busy_ms_next + 16'd1;
                    if (retry_ms_next != 16'hFFFF) retry_ms_next = retry_ms_next + 16'd1;
                end
                if (!tx_busy_next) busy_ms_next = '0;
                if (busy_ms_next >= bto_reg)
                begin
                    busy_ms_next = '0;
                    tx_busy_next = 1'b0;
                end
                if (in_word.tx_done) tx_busy_next = 1'b0;
                if (!tx_busy_next)
                begin
                    if (!status.proc_empty)
                    begin
                        res_next.send_valid  = 1'b1;
                        res_next.send_id     = status.proc_head.id;
                        res_next.send_remote = status.proc_head.remote;
                        res_next.send_length = status.proc_head.len;
                        res_next.send_w0     = status.proc_head.w0;
                        res_next.send_w1     = status.proc_head.w1;
                        res_next.send_w2     = status.proc_head.w2;
                        res_next.send_w3     = status.proc_head.w3;
                        cmd.pop_proc         = 1'b1;
                        tx_busy_next         = 1'b1;
                    end
                    else
                    begin
                        // a finished request is dropped; the entry behind it
                        // is served in the same tick
                        if (!await_reg && att_reg != 8'd0)
                        begin
                            att_next = '0;
                            if (!s_empty)
                            begin
                                cmd.drop_serv = 1'b1;
                                s_empty = status.serv_next_empty;
                                f = status.serv_next;
                            end
                        end
                        if (!s_empty && (!await_reg || retry_ms_next >= rint_reg))
                        begin
                            if (await_reg)
                            begin
                                retry_ms_next = '0;
                                if (att_next != 8'hFF) att_next = att_next + 8'd1;
                                if (att_next >= rlim_reg)
                                begin
                                    res_next.retry_fault = 1'b1;
                                    await_next = 1'b0;
                                end
                            end
                            res_next.send_valid  = 1'b1;
                            res_next.send_id     = f.id;
                            res_next.send_remote = f.remote;
                            res_next.send_length = f.len;
                            res_next.send_w0     = f.w0;
                            res_next.send_w1     = f.w1;
                            res_next.send_w2     = f.w2;
                            res_next.send_w3     = f.w3;
                            if (att_next == 8'd0)
                            begin
                                if (f.ack)
                                begin
                                    await_next    = 1'b1;
                                    att_next      = 8'd1;
                                    retry_ms_next = '0;
                                    pidx_next     = {f.w1[7:0], f.w0[15:8]};
                                    psub_next     = f.w1[15:8];
                                    pnode_next    = f.id[6:0];
                                end
                                else cmd.pop_serv = 1'b1;
                            end
                            tx_busy_next = 1'b1;
                        end
                    end
                end
            end
            MODE_RECV:
            begin
                if (!in_word.remote_request && await_reg
                    && {in_word.data_w1[7:0], in_word.data_w0[15:8]} == pidx_reg
                    && in_word.data_w1[15:8] == psub_reg
                    && in_word.frame_id[6:0] == pnode_reg)
                begin
                    await_next           = 1'b0;
                    res_next.ack_matched = 1'b1;
                end
            end
            default: ;
        endcase
        res_next.busy_res = tx_busy_next;
        state_next = state_reg;
        if (step) state_next = ST_FULL;
        else if (out_ready) state_next = ST_EMPTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_EMPTY;
            res_reg      <= '0;
            bto_reg      <= BUSY_TIMEOUT_RESET;
            rint_reg     <= RETRY_INTERVAL_RESET;
            rlim_reg     <= RETRY_LIMIT_RESET;
            last_reg     <= '0;
            busy_ms_reg  <= '0;
            retry_ms_reg <= '0;
            tx_busy_reg  <= 1'b0;
            await_reg    <= 1'b0;
            att_reg      <= '0;
            pidx_reg     <= '0;
            psub_reg     <= '0;
            pnode_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_BUSY_TIMEOUT)   bto_reg  <= cfg_data;
                if (cfg_index == REG_RETRY_INTERVAL) rint_reg <= cfg_data;
                if (cfg_index == REG_RETRY_LIMIT)    rlim_reg <= cfg_data[7:0];
            end
            if (step)
            begin
                res_reg      <= res_next;
                last_reg     <= last_next;
                busy_ms_reg  <= busy_ms_next;
                retry_ms_reg <= retry_ms_next;
                tx_busy_reg  <= tx_busy_next;
                await_reg    <= await_next;
                att_reg      <= att_next;
                pidx_reg     <= pidx_next;
                psub_reg     <= psub_next;
                pnode_reg    <= pnode_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_fault_clears_ack: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_next.retry_fault |=> !await_reg)
        else $error("fault left ack pending");
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_next.send_valid |=> tx_busy_reg)
        else $error("send without busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(res_reg))
        else $error("result changed while stalled");
    a_await_att: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> att_reg != 8'd0)
        else $error("ack pending with zero attempts");
`endif

endmodule
